/* rtl/core/lzss_decompressor_core_macros.svh */
// Assertion shorthands shared by the decoder modules.
// Each expects i_clk and i_rst_n in the scope of the module that uses it.
`ifndef LZSS_DECOMPRESSOR_CORE_MACROS_SVH
`define LZSS_DECOMPRESSOR_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LZD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LZD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lzd_pkg.sv */
package lzd_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int RING_AW    = 12;
    localparam int FILL_W     = RING_AW + 1;
    localparam int MAX_MATCH  = 18;
    localparam int MATCH_BIAS = 3;
    localparam int REMAIN_W   = 5;

    localparam logic [7:0]         SPACE_CHAR = 8'h20;
    localparam logic [7:0]         FLAG_LOAD  = 8'hFF;
    localparam logic [RING_AW-1:0] WP_RESET   = RING_AW'(RING_DEPTH - MAX_MATCH);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               init;
        logic               emit_lit;
        logic               set_src;
        logic [RING_AW-1:0] src;
        logic               copy_step;
        logic               copy_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/core/lzd_in_if.sv */
interface lzd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       block_end;

    modport source (output valid, output in_byte, output block_end, input ready);
    modport sink   (input valid, input in_byte, input block_end, output ready);
endinterface

/* rtl/core/lzd_out_if.sv */
interface lzd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* rtl/core/lzss_decompressor_core.sv */
// LZSS decoder with a 4096-byte history and matches of 3 to 18 bytes. One
// compressed byte is taken per input beat. A flag byte or the first byte of a
// match gives no output, and a literal gives one beat. Accepting the second
// byte of a match starts the first history read; the match then gives 3 to 18
// beats at one per cycle while the output is not stalled. Each copied byte
// comes from a registered history RAM read and is written back through its
// separate write port as it is issued. While a match is being copied no input
// is taken; output stalls hold up literals and copies alike. A beat with
// block_end set returns the decoder to its start state once its output has
// been issued: the history reads as spaces again at once, with no clearing
// pass, and the write pointer restarts at 4078. A token cut short by the end
// of a block is dropped.
module lzss_decompressor_core import lzd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lzd_in_if.sink    i_in_ch,
    lzd_out_if.source o_out_ch
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lzd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (i_in_ch),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lzd_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_in_byte (i_in_ch.in_byte),
        .o_stat    (stat),
        .o_out_ch  (o_out_ch)
    );

endmodule

/* rtl/core/lzd_ctrl.sv */
`include "lzss_decompressor_core_macros.svh"

module lzd_ctrl import lzd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lzd_in_if.sink   i_in_ch,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_COPY
    } t_state;

    t_state              r_state,    n_state;
    logic [15:0]         r_flags,    n_flags;
    logic                r_phase,    n_phase;
    logic [7:0]          r_pos_low,  n_pos_low;
    logic [REMAIN_W-1:0] r_remain,   n_remain;
    logic                r_end_pend, n_end_pend;
    logic                accept;

    assign i_in_ch.ready = (r_state == ST_IDLE) && i_stat.out_free;
    assign accept        = i_in_ch.valid && i_in_ch.ready;

    always_comb begin
        n_state    = r_state;
        n_flags    = r_flags;
        n_phase    = r_phase;
        n_pos_low  = r_pos_low;
        n_remain   = r_remain;
        n_end_pend = r_end_pend;
        o_cmd      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_phase) begin
                        o_cmd.set_src = 1'b1;
                        o_cmd.src     = {i_in_ch.in_byte[7:4], r_pos_low};
                        n_remain      = REMAIN_W'({1'b0, i_in_ch.in_byte[3:0]})
                                        + REMAIN_W'(MATCH_BIAS - 1);
                        n_flags       = r_flags >> 1;
                        n_phase       = 1'b0;
                        n_end_pend    = i_in_ch.block_end;
                        n_state       = ST_COPY;
                    end else if (!r_flags[8]) begin
                        n_flags = {FLAG_LOAD, i_in_ch.in_byte};
                    end else if (r_flags[0]) begin
                        o_cmd.emit_lit = 1'b1;
                        n_flags        = r_flags >> 1;
                    end else begin
                        n_pos_low = i_in_ch.in_byte;
                        n_phase   = 1'b1;
                    end
                    // A block ending mid-token drops the token; a match runs on first.
                    if (i_in_ch.block_end && !r_phase) begin
                        o_cmd.init = 1'b1;
                        n_flags    = '0;
                        n_phase    = 1'b0;
                        n_pos_low  = '0;
                    end
                end
            end
            ST_COPY: begin
                if (i_stat.out_free) begin
                    o_cmd.copy_step = 1'b1;
                    o_cmd.copy_last = (r_remain == '0);
                    n_remain        = r_remain - REMAIN_W'(1);
                    if (r_remain == '0) begin
                        n_state = ST_IDLE;
                        if (r_end_pend) begin
                            o_cmd.init = 1'b1;
                            n_flags    = '0;
                            n_phase    = 1'b0;
                            n_pos_low  = '0;
                            n_end_pend = 1'b0;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_flags    <= '0;
            r_phase    <= 1'b0;
            r_pos_low  <= '0;
            r_remain   <= '0;
            r_end_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_flags    <= n_flags;
            r_phase    <= n_phase;
            r_pos_low  <= n_pos_low;
            r_remain   <= n_remain;
            r_end_pend <= n_end_pend;
        end
    end

    `LZD_ASSERT_NEXT(a_remain_count, (r_state == ST_COPY) && o_cmd.copy_step && (r_remain != '0), r_remain == $past(r_remain) - REMAIN_W'(1), "copy count did not step down")
    `LZD_ASSERT_NEXT(a_last_to_idle, o_cmd.copy_step && o_cmd.copy_last, r_state == ST_IDLE, "copy did not end after its last beat")
    `LZD_ASSERT_NOW(a_lit_needs_flag, o_cmd.emit_lit, r_flags[8] && r_flags[0], "literal emitted without a literal flag bit")

endmodule

/* rtl/core/lzd_datapath.sv */
`include "lzss_decompressor_core_macros.svh"

module lzd_datapath import lzd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_in_byte,
    output t_dp_stat   o_stat,
    lzd_out_if.source  o_out_ch
);

    logic [7:0]         mem [RING_DEPTH];
    logic [RING_AW-1:0] r_wp,       n_wp;
    logic [FILL_W-1:0]  r_fill,     n_fill;
    logic [RING_AW-1:0] r_rd_addr,  n_rd_addr;
    logic [7:0]         r_rd_data;
    logic               r_rd_valid, n_rd_valid;
    logic               r_fwd_hit,  n_fwd_hit;
    logic [7:0]         r_fwd_data;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic [RING_AW-1:0] rd_off;
    logic [7:0]         cur_byte;
    logic [7:0]         wr_data;
    logic               wr_en;

    assign o_stat.out_free = !r_out_valid || o_out_ch.ready;

    // Entries never written since the block started read as spaces. Writes fill
    // the ring contiguously from the start pointer, so a count says which are live.
    assign cur_byte = r_fwd_hit ? r_fwd_data : (r_rd_valid ? r_rd_data : SPACE_CHAR);
    assign wr_en    = i_cmd.emit_lit || i_cmd.copy_step;
    assign wr_data  = i_cmd.emit_lit ? i_in_byte : cur_byte;

    always_comb begin
        if (i_cmd.set_src) begin
            n_rd_addr = i_cmd.src;
        end else if (i_cmd.copy_step) begin
            n_rd_addr = r_rd_addr + RING_AW'(1);
        end else begin
            n_rd_addr = r_rd_addr;
        end
        rd_off     = n_rd_addr - WP_RESET;
        n_rd_valid = {1'b0, rd_off} < r_fill;
        // The RAM returns old data when read and written at one address in a cycle.
        n_fwd_hit  = wr_en && (r_wp == n_rd_addr);

        if (i_cmd.init) begin
            n_wp   = WP_RESET;
            n_fill = '0;
        end else if (wr_en) begin
            n_wp   = r_wp + RING_AW'(1);
            n_fill = (r_fill == FILL_W'(RING_DEPTH)) ? r_fill : r_fill + FILL_W'(1);
        end else begin
            n_wp   = r_wp;
            n_fill = r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wp] <= wr_data;
        end
        r_rd_data <= mem[n_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr  <= n_rd_addr;
        r_fwd_data <= wr_data;
        if (wr_en) begin
            r_out_byte <= wr_data;
            r_out_last <= i_cmd.emit_lit || i_cmd.copy_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= WP_RESET;
            r_fill      <= '0;
            r_rd_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wp       <= n_wp;
            r_fill     <= n_fill;
            r_rd_valid <= n_rd_valid;
            r_fwd_hit  <= n_fwd_hit;
            if (wr_en) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.out_byte    = r_out_byte;
    assign o_out_ch.last_of_run = r_out_last;

    `LZD_ASSERT_NOW(a_no_overwrite, wr_en, !r_out_valid || o_out_ch.ready, "result beat overwritten before it was taken")
    `LZD_ASSERT_NEXT(a_wp_step, wr_en && !i_cmd.init, r_wp == $past(r_wp) + RING_AW'(1), "write pointer did not advance")

endmodule

/* dv/lzss_decompressor_core_tb.sv */
`timescale 1ns / 100ps

module lzss_decompressor_core_tb import lzd_pkg::*; ();

    localparam int DIRECTED_N   = 22;
    localparam int RANDOM_ITEMS = 208;
    localparam int LIMIT_CYCLES = 300000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    // Decoder state kept alongside the block, plus the bytes it still owes.
    class lzss_byte_predictor;
        logic [7:0]         history [RING_DEPTH];
        logic [RING_AW-1:0] wr_pos;
        logic [15:0]        flags;
        bit                 want_second;
        logic [7:0]         low_pos;
        t_out_beat          due_bytes[$];
        int unsigned        errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            foreach (history[i]) history[i] = SPACE_CHAR;
            wr_pos      = WP_RESET;
            flags       = '0;
            want_second = 1'b0;
            low_pos     = '0;
        endfunction

        function void store_and_owe(logic [7:0] v, logic last);
            t_out_beat beat;
            beat.data = v;
            beat.last = last;
            due_bytes.push_back(beat);
            history[wr_pos] = v;
            wr_pos = wr_pos + 1'b1;
        endfunction

        function void take_code_byte(logic [7:0] code, logic blk_end);
            logic [RING_AW-1:0] src;
            int                 len;
            if (want_second) begin
                src = {code[7:4], low_pos};
                len = int'(code[3:0]) + MATCH_BIAS;
                // Each copied byte is written back before the next read, so
                // overlapping copies repeat what was just produced.
                for (int n = 0; n < len; n++) begin
                    store_and_owe(history[src + RING_AW'(n)], n == len - 1);
                end
                flags       = flags >> 1;
                want_second = 1'b0;
            end else if (!flags[8]) begin
                flags = {FLAG_LOAD, code};
            end else if (flags[0]) begin
                store_and_owe(code, 1'b1);
                flags = flags >> 1;
            end else begin
                low_pos     = code;
                want_second = 1'b1;
            end
            if (blk_end) restart();
        endfunction

        function void check_out_byte(logic [7:0] data, logic last);
            t_out_beat want;
            if (due_bytes.size() == 0) begin
                $error("out_byte: expected nothing, actual %0h (last_of_run %0b)", data, last);
                errors++;
                return;
            end
            want = due_bytes.pop_front();
            if (data !== want.data) begin
                $error("out_byte: expected %0h, actual %0h", want.data, data);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_run: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;
    int   sent;
    int   cycles;

    lzss_byte_predictor predictor = new();

    lzd_in_if  in_ch();
    lzd_out_if out_ch();

    lzss_decompressor_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (in_ch),
        .o_out_ch(out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("lzss_decompressor_core_tb: errors");
            $finish;
        end
    end

    // Output side: check the beat taken at this edge, then choose the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            predictor.check_out_byte(out_ch.out_byte, out_ch.last_of_run);
        end
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 24);
    end

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic push_code_byte(input logic [7:0] code, input logic blk_end);
        while (!no_idle && $urandom_range(0, 99) < 24) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= code;
        in_ch.block_end <= blk_end;
        do @(posedge i_clk); while (!in_ch.ready);
        predictor.take_code_byte(code, blk_end);
        sent++;
    endtask

    initial begin
        logic [8:0]   directed [DIRECTED_N];
        logic [7:0]   flag;
        logic [11:0]  gen_wp;
        logic [11:0]  src;
        logic [3:0]   nib;
        int           ntok;
        int           blk;
        bit           fin;
        bit           cut;

        // Each entry is {block_end, byte}.
        directed = '{
            // Literal, an overlapping 18-byte copy from the start position,
            // then six literals; the next byte must be read as a flag again.
            {1'b0, 8'hFD}, {1'b0, 8'h00}, {1'b0, 8'hEE}, {1'b0, 8'hFF},
            {1'b0, 8'hFF}, {1'b0, 8'hA5}, {1'b0, 8'h5A}, {1'b0, 8'h80},
            {1'b0, 8'h01}, {1'b0, 8'h7F},
            // Shortest matches at position 0 and wrapping past the top, then
            // a match whose second byte never comes.
            {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'hFF},
            {1'b0, 8'hF0}, {1'b1, 8'h12},
            // A flag byte alone at the end of a block.
            {1'b1, 8'h55},
            // A literal that ends its block.
            {1'b0, 8'h01}, {1'b1, 8'hC3},
            // A full-length match of untouched history ending the block.
            {1'b0, 8'h00}, {1'b0, 8'h34}, {1'b1, 8'h1F}
        };

        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.in_byte   <= '0;
        in_ch.block_end <= 1'b0;
        no_idle          = 1'b0;
        sent             = 0;
        blk              = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) push_code_byte(directed[i][7:0], directed[i][8]);

        while (sent < DIRECTED_N + RANDOM_ITEMS) begin
            blk++;
            if (blk == 3) begin
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (predictor.due_bytes.size() != 0);
            end
            no_idle = (sent >= 110 && sent < 160);
            if ($urandom_range(0, 9) == 0) begin
                // Unstructured bytes, which the decoder still has to parse.
                ntok = $urandom_range(1, 12);
                for (int t = 0; t < ntok; t++) begin
                    push_code_byte(8'($urandom_range(0, 255)),
                                   t == ntok - 1 || $urandom_range(0, 15) == 0);
                end
            end else begin
                gen_wp = WP_RESET;
                ntok   = $urandom_range(1, 40);
                cut    = ($urandom_range(0, 7) == 0);
                for (int t = 0; t < ntok; t++) begin
                    fin = (t == ntok - 1);
                    if (t % 8 == 0) begin
                        flag = 8'($urandom_range(0, 255));
                        push_code_byte(flag, 1'b0);
                    end
                    if (flag[t % 8]) begin
                        push_code_byte(8'($urandom_range(0, 255)), fin);
                        gen_wp = gen_wp + 1'b1;
                    end else begin
                        // Mostly point back into recently written history.
                        if ($urandom_range(0, 3) != 0)
                            src = gen_wp - 12'($urandom_range(1, 64));
                        else
                            src = 12'($urandom_range(0, RING_DEPTH - 1));
                        nib = ($urandom_range(0, 5) == 0) ? 4'hF : 4'($urandom_range(0, 15));
                        if (fin && cut) begin
                            push_code_byte(src[7:0], 1'b1);
                        end else begin
                            push_code_byte(src[7:0], 1'b0);
                            push_code_byte({src[11:8], nib}, fin);
                            gen_wp = gen_wp + 12'(nib) + 12'(MATCH_BIAS);
                        end
                    end
                end
            end
        end

        in_ch.valid <= 1'b0;
        no_idle = 1'b0;
        do @(posedge i_clk); while (predictor.due_bytes.size() != 0);
        repeat (2 * MAX_MATCH + 4) @(posedge i_clk);

        if (predictor.errors == 0 && predictor.due_bytes.size() == 0) begin
            $display("lzss_decompressor_core_tb: clean");
        end else begin
            $display("lzss_decompressor_core_tb: errors");
        end
        $finish;
    end

endmodule
